// ===== design/tpe_pkg.sv =====
// Shared types and constants for the P1 triangle Poisson element block.
`default_nettype none
package tpe_pkg;

    localparam int IN_W   = 296;
    localparam int OUT_W  = 192;
    localparam int USER_W = 4;

    localparam logic [31:0] KAPPA_RESET = 32'h0001_0000;

    // 24 * 2^32: load denominator in raw units
    localparam logic [68:0] LOAD_DEN = 69'h18_0000_0000;
    localparam logic [47:0] POS_LIM  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIM  = 48'h8000_0000_0000;

    typedef struct packed {
        logic [2:0][33:0] gx;
        logic [2:0][33:0] gy;
        logic [2:0][33:0] ssum;
        logic [66:0]      det;
        logic             degen;
        logic [2:0]       mask;
    } elem_t;

endpackage
`default_nettype wire

// ===== design/tpe_front.sv =====
// Front end: accepts triangles, forms edge vectors, gradients, determinant.
`default_nettype none
module tpe_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [tpe_pkg::IN_W-1:0]  in_data,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output tpe_pkg::elem_t                 q_data
);

    logic        v1_reg, v2_reg, adv;
    logic [32:0] a_reg, b_reg, c_reg, d_reg;
    logic [33:0] s0_reg, s1_reg, s2_reg;
    logic [2:0]  m1_reg;

    logic [32:0] a_next, b_next, c_next, d_next;
    logic [33:0] s0_next, s1_next, s2_next, fsum;
    logic [31:0] x0, y0, x1, y1, x2, y2, f0, f1, f2;

    logic signed [65:0] ad_reg, bc_reg, ad_next, bc_next;
    logic [2:0][33:0]   gx_reg, gy_reg, gx_next, gy_next;
    logic [2:0][33:0]   ss_reg;
    logic [2:0]         m2_reg;
    logic [66:0]        det;

    assign adv      = !v2_reg || q_ready;
    assign in_ready = adv;

    always_comb
    begin
        x0 = in_data[31:0];
        y0 = in_data[63:32];
        x1 = in_data[95:64];
        y1 = in_data[127:96];
        x2 = in_data[159:128];
        y2 = in_data[191:160];
        f0 = in_data[223:192];
        f1 = in_data[255:224];
        f2 = in_data[287:256];
        a_next  = {x1[31], x1} - {x0[31], x0};
        b_next  = {y1[31], y1} - {y0[31], y0};
        c_next  = {x2[31], x2} - {x0[31], x0};
        d_next  = {y2[31], y2} - {y0[31], y0};
        fsum    = {{2{f0[31]}}, f0} + {{2{f1[31]}}, f1} + {{2{f2[31]}}, f2};
        s0_next = fsum + {{2{f0[31]}}, f0};
        s1_next = fsum + {{2{f1[31]}}, f1};
        s2_next = fsum + {{2{f2[31]}}, f2};
    end

    always_comb
    begin
        ad_next    = $signed(a_reg) * $signed(d_reg);
        bc_next    = $signed(b_reg) * $signed(c_reg);
        gx_next[0] = {b_reg[32], b_reg} - {d_reg[32], d_reg};
        gy_next[0] = {c_reg[32], c_reg} - {a_reg[32], a_reg};
        gx_next[1] = {d_reg[32], d_reg};
        gy_next[1] = 34'd0 - {c_reg[32], c_reg};
        gx_next[2] = 34'd0 - {b_reg[32], b_reg};
        gy_next[2] = {a_reg[32], a_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            c_reg  <= c_next;
            d_reg  <= d_next;
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            m1_reg <= in_data[290:288];
            ad_reg <= ad_next;
            bc_reg <= bc_next;
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            ss_reg <= {s2_reg, s1_reg, s0_reg};
            m2_reg <= m1_reg;
        end
    end

    assign det = {ad_reg[65], ad_reg} - {bc_reg[65], bc_reg};

    assign q_valid = v2_reg;

    always_comb
    begin
        q_data.gx    = gx_reg;
        q_data.gy    = gy_reg;
        q_data.ssum  = ss_reg;
        q_data.det   = det;
        q_data.degen = (det == 67'd0);
        q_data.mask  = m2_reg;
    end

endmodule
`default_nettype wire

// ===== design/tpe_queue.sv =====
// Two-entry queue of classified elements between front and back.
`default_nettype none
module tpe_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire tpe_pkg::elem_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output tpe_pkg::elem_t      rd_data
);

    tpe_pkg::elem_t ent_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_fire)
                wp_reg <= !wp_reg;
            if (rd_fire)
                rp_reg <= !rp_reg;
            if (wr_fire && !rd_fire)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd_fire && !wr_fire)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            ent_reg[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== design/tpe_back.sv =====
// Back end: sequenced multiply and radix-4 divide for stiffness and load rows.
`default_nettype none
module tpe_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [31:0]                kappa,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire tpe_pkg::elem_t             q_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [tpe_pkg::OUT_W-1:0]       out_data,
    output logic [tpe_pkg::USER_W-1:0]      out_user,
    output logic                            out_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROD = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]            st_reg, st_next;
    tpe_pkg::elem_t        el_reg, el_next;
    logic [1:0]            row_reg, row_next, col_reg, col_next;
    logic signed [67:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic [68:0]           am_reg, am_next, dm_reg, dm_next;
    logic [33:0]           bm_reg, bm_next;
    logic                  neg_reg, neg_next, sat_reg, sat_next;
    logic [68:0]           plo_reg, plo_next;
    logic [67:0]           phi_reg, phi_next;
    logic [103:0]          n_reg, n_next;
    logic [117:0]          ds_reg, ds_next;
    logic [47:0]           q_reg, q_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [3:0][47:0]      val_reg, val_next;
    logic                  ov_reg, ov_next, ol_reg, ol_next;
    logic [tpe_pkg::OUT_W-1:0]  od_reg, od_next;
    logic [tpe_pkg::USER_W-1:0] ou_reg, ou_next;

    logic        skip, act;
    logic [33:0] gxj, gxk, gyj, gyk, sj;
    logic [68:0] dot, dotm;
    logic [66:0] detm;
    logic [31:0] km;
    logic [103:0] pw, nw, n1;
    logic [69:0] dw;
    logic        b1, b2;
    logic [47:0] wv;

    function automatic logic [33:0] pick(input logic [2:0][33:0] arr, input logic [1:0] idx);
        logic [33:0] r;
        case (idx)
            2'd1:    r = arr[1];
            2'd2:    r = arr[2];
            default: r = arr[0];
        endcase
        return r;
    endfunction

    always_comb
    begin
        act  = !el_reg.mask[row_reg];
        skip = !act || el_reg.degen;
        gxj  = pick(el_reg.gx, row_reg);
        gyj  = pick(el_reg.gy, row_reg);
        gxk  = pick(el_reg.gx, col_reg);
        gyk  = pick(el_reg.gy, col_reg);
        sj   = pick(el_reg.ssum, row_reg);
        dot  = {p1_reg[67], p1_reg} + {p2_reg[67], p2_reg};
        dotm = dot[68] ? 69'd0 - dot : dot;
        detm = el_reg.det[66] ? 67'd0 - el_reg.det : el_reg.det;
        km   = kappa[31] ? 32'd0 - kappa : kappa;
        pw   = {35'd0, plo_reg} + {1'b0, phi_reg, 35'd0};
        nw   = {pw[102:0], 1'b0} + {35'd0, dm_reg};
        dw   = {dm_reg, 1'b0};
        b1   = ({14'd0, n_reg} >= ds_reg);
        n1   = b1 ? n_reg - ds_reg[103:0] : n_reg;
        b2   = ({14'd0, n1} >= {1'b0, ds_reg[117:1]});
        if (neg_reg)
            wv = (sat_reg || q_reg > tpe_pkg::NEG_LIM) ? tpe_pkg::NEG_LIM : 48'd0 - q_reg;
        else
            wv = (sat_reg || q_reg > tpe_pkg::POS_LIM) ? tpe_pkg::POS_LIM : q_reg;
    end

    always_comb
    begin
        st_next  = st_reg;
        el_next  = el_reg;
        row_next = row_reg;
        col_next = col_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        am_next  = am_reg;
        bm_next  = bm_reg;
        dm_next  = dm_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        plo_next = plo_reg;
        phi_next = phi_reg;
        n_next   = n_reg;
        ds_next  = ds_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        val_next = val_reg;
        od_next  = od_reg;
        ou_next  = ou_reg;
        ol_next  = ol_reg;
        ov_next  = (ov_reg && !out_ready);
        q_ready  = 1'b0;

        case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready  = 1'b1;
                    el_next  = q_data;
                    row_next = 2'd0;
                    col_next = 2'd0;
                    st_next  = S_PROD;
                end
            end
            S_PROD:
            begin
                if (skip)
                begin
                    val_next[col_reg] = 48'd0;
                    if (col_reg == 2'd3)
                        st_next = S_EMIT;
                    else
                        col_next = col_reg + 2'd1;
                end
                else
                begin
                    p1_next = $signed(gxj) * $signed(gxk);
                    p2_next = $signed(gyj) * $signed(gyk);
                    st_next = S_MAG;
                end
            end
            S_MAG:
            begin
                if (col_reg == 2'd3)
                begin
                    am_next  = {2'd0, detm};
                    bm_next  = sj[33] ? 34'd0 - sj : sj;
                    dm_next  = tpe_pkg::LOAD_DEN;
                    neg_next = el_reg.det[66] ^ sj[33];
                end
                else
                begin
                    am_next  = dotm;
                    bm_next  = {2'd0, km};
                    dm_next  = {1'b0, detm, 1'b0};
                    neg_next = dot[68] ^ kappa[31] ^ el_reg.det[66];
                end
                st_next = S_MUL;
            end
            S_MUL:
            begin
                plo_next = am_reg[34:0] * bm_reg;
                phi_next = am_reg[68:35] * bm_reg;
                st_next  = S_PREP;
            end
            S_PREP:
            begin
                n_next   = nw;
                sat_next = ({14'd0, nw} >= {dw, 48'd0});
                ds_next  = {1'b0, dw, 47'd0};
                q_next   = 48'd0;
                cnt_next = 5'd23;
                st_next  = S_DIV;
            end
            S_DIV:
            begin
                n_next   = b2 ? n1 - ds_reg[104:1] : n1;
                ds_next  = {2'd0, ds_reg[117:2]};
                q_next   = {q_reg[45:0], b1, b2};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    st_next = S_WB;
            end
            S_WB:
            begin
                val_next[col_reg] = wv;
                if (col_reg == 2'd3)
                    st_next = S_EMIT;
                else
                begin
                    col_next = col_reg + 2'd1;
                    st_next  = S_PROD;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = {val_reg[3], val_reg[2], val_reg[1], val_reg[0]};
                    ou_next = {el_reg.degen, act, row_reg};
                    ol_next = (row_reg == 2'd2);
                    if (row_reg == 2'd2)
                        st_next = S_IDLE;
                    else
                    begin
                        row_next = row_reg + 2'd1;
                        col_next = 2'd0;
                        st_next  = S_PROD;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            row_reg <= 2'd0;
            col_reg <= 2'd0;
            cnt_reg <= 5'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            row_reg <= row_next;
            col_reg <= col_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg  <= el_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        am_reg  <= am_next;
        bm_reg  <= bm_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        n_reg   <= n_next;
        ds_reg  <= ds_next;
        q_reg   <= q_next;
        val_reg <= val_next;
        od_reg  <= od_next;
        ou_reg  <= ou_next;
        ol_reg  <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_user  = ou_reg;
    assign out_last  = ol_reg;

endmodule
`default_nettype wire

// ===== design/p1_triangle_poisson_element.sv =====
// Top level: P1 triangle element stiffness rows and load, stream ports.
// Path: front end registers and the two-entry queue, then per row 4 values
// (3 stiffness columns and the load), each through product, magnitude, multiply,
// prepare, divide and write-back (zero if the row is on the boundary or the
// element is degenerate), then emit. The back end works on one element
// at a time, paced by the shared multiplier and the 2-bit-per-cycle divider.
`default_nettype none
module p1_triangle_poisson_element (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [31:0]                 cfg_data,      // diffusion_coeff
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // x0, y0, x1, y1, x2, y2, src0, src1, src2, boundary_mask, zero pad
    input  wire logic [tpe_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // stiff_col0, stiff_col1, stiff_col2, load_value
    output logic [tpe_pkg::OUT_W-1:0]        m_axis_tdata,
    // local_row[1:0], row_active, degenerate
    output logic [tpe_pkg::USER_W-1:0]       m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic [31:0]    kappa_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    tpe_pkg::elem_t fq_data, qb_data;

    // Reset (rst_n low, asynchronous): queue and pipelines empty, kappa = 1.0.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kappa_reg <= tpe_pkg::KAPPA_RESET;
        else if (cfg_valid && cfg_ready)
            kappa_reg <= cfg_data;
    end

    tpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    tpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    tpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .kappa     (kappa_reg),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the P1 triangle Poisson element block.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] x0, y0, x1, y1, x2, y2, f0, f1, f2;
        logic [2:0]  mask;
    } tri_t;

    typedef struct {
        logic [1:0]  row;
        logic        active;
        logic        degen;
        logic        last;
        logic [47:0] k0, k1, k2, ld;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [tpe_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [tpe_pkg::OUT_W-1:0] m_axis_tdata;
    logic [tpe_pkg::USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    tri_t pend_tris[$];
    tri_t cur_tri;
    row_t rows_due[$];
    logic [31:0] kappa = tpe_pkg::KAPPA_RESET;
    int   queued_cnt = 0;
    int   taken_cnt = 0;
    int   errors = 0;
    bit   in_done = 0;
    bit   out_done = 0;
    bit   cfg_done = 0;
    bit   no_idle = 0;
    bit   hold_go = 0;
    bit   hold_seen = 0;
    int   hold_left = 0;
    int   in_gap = 0;
    int   out_stall = 0;

    p1_triangle_poisson_element dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // num/den rounded half away from zero, saturated to 48 bits
    function automatic logic [47:0] round_sat(logic signed [127:0] num,
                                              logic signed [127:0] den);
        logic neg;
        logic [127:0] n, d, q;
        begin
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (2 * n + d) / (2 * d);
            if (neg)
                round_sat = (q > 128'h8000_0000_0000) ? tpe_pkg::NEG_LIM : 48'(-q);
            else
                round_sat = (q > 128'h7FFF_FFFF_FFFF) ? tpe_pkg::POS_LIM : q[47:0];
        end
    endfunction

    task automatic predict_rows(tri_t t);
        logic signed [127:0] a, b, c, d, det, dot, fs, fj;
        logic signed [127:0] gx[3], gy[3], kv;
        logic [47:0] kk[3];
        row_t r;
        bit degen;
        begin
            a = $signed(t.x1) - $signed(t.x0);
            b = $signed(t.y1) - $signed(t.y0);
            c = $signed(t.x2) - $signed(t.x0);
            d = $signed(t.y2) - $signed(t.y0);
            gx[0] = b - d; gy[0] = c - a;
            gx[1] = d;     gy[1] = -c;
            gx[2] = -b;    gy[2] = a;
            det = a * d - b * c;
            degen = (det == 0);
            kv = $signed(kappa);
            fs = 128'(signed'(t.f0)) + 128'(signed'(t.f1)) + 128'(signed'(t.f2));
            for (int j = 0; j < 3; j++)
            begin
                r.row = 2'(j);
                r.active = !t.mask[j];
                r.degen = degen;
                r.last = (j == 2);
                fj = (j == 0) ? 128'(signed'(t.f0)) :
                     (j == 1) ? 128'(signed'(t.f1)) : 128'(signed'(t.f2));
                for (int k = 0; k < 3; k++)
                begin
                    kk[k] = '0;
                    if (r.active && !degen)
                    begin
                        dot = gx[j] * gx[k] + gy[j] * gy[k];
                        kk[k] = round_sat(dot * kv, 2 * det);
                    end
                end
                r.k0 = kk[0]; r.k1 = kk[1]; r.k2 = kk[2];
                r.ld = (r.active && !degen) ?
                       round_sat(det * (fj + fs), 128'(tpe_pkg::LOAD_DEN)) : '0;
                rows_due.push_back(r);
            end
        end
    endtask

    function automatic logic [31:0] rnd_coord(int sel);
        begin
            case (sel)
                0: rnd_coord = $urandom;
                1: rnd_coord = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
                default: rnd_coord = 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            endcase
        end
    endfunction

    function automatic tri_t rnd_tri();
        tri_t t;
        int sel;
        begin
            sel = $urandom_range(0, 9);
            t.x0 = rnd_coord(sel % 3); t.y0 = rnd_coord(sel % 3);
            t.x1 = rnd_coord(sel % 3); t.y1 = rnd_coord(sel % 3);
            t.x2 = rnd_coord(sel % 3); t.y2 = rnd_coord(sel % 3);
            if (sel == 9)
            begin
                // collinear: third vertex mirrors the second about the first
                t.x2 = 2 * t.x0 - t.x1;
                t.y2 = 2 * t.y0 - t.y1;
            end
            t.f0 = ($urandom_range(0, 3) == 0) ? $urandom : rnd_coord(1);
            t.f1 = ($urandom_range(0, 3) == 0) ? $urandom : rnd_coord(1);
            t.f2 = ($urandom_range(0, 3) == 0) ? $urandom : rnd_coord(1);
            t.mask = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
            rnd_tri = t;
        end
    endfunction

    task automatic add_tri(logic [31:0] x0, y0, x1, y1, x2, y2, f0, f1, f2,
                           logic [2:0] m);
        tri_t t;
        begin
            t.x0 = x0; t.y0 = y0; t.x1 = x1; t.y1 = y1; t.x2 = x2; t.y2 = y2;
            t.f0 = f0; t.f1 = f1; t.f2 = f2; t.mask = m;
            pend_tris.push_back(t);
            queued_cnt++;
        end
    endtask

    task automatic write_kappa(logic [31:0] v);
        begin
            @(negedge clk);
            cfg_done = 0;
            cfg_valid <= 1'b1;
            cfg_data <= v;
            do @(negedge clk); while (!cfg_done);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            do @(negedge clk); while (taken_cnt != queued_cnt || rows_due.size() != 0);
            repeat (20) @(negedge clk);
        end
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_done))
        begin
            in_done = 0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pend_tris.size() != 0)
            begin
                cur_tri = pend_tris.pop_front();
                s_axis_tdata <= {5'b0, cur_tri.mask, cur_tri.f2, cur_tri.f1, cur_tri.f0,
                                 cur_tri.y2, cur_tri.x2, cur_tri.y1, cur_tri.x1,
                                 cur_tri.y0, cur_tri.x0};
                s_axis_tvalid <= 1'b1;
                in_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_seen = 1;
            hold_left = 3000;
        end
        else if (hold_left > 0)
            hold_left--;
    end

    // output ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_done)
            begin
                out_done = 0;
                out_stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= (hold_left == 0);
        end
    end

    // transfers and checking
    always @(posedge clk)
    begin
        row_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                kappa = cfg_data;
                cfg_done = 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_rows(cur_tri);
                taken_cnt++;
                in_done = 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_done = 1;
                if (rows_due.size() == 0)
                begin
                    $display("%0t: unexpected row, actual data %h user %h", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    e = rows_due.pop_front();
                    if (m_axis_tuser !== {e.degen, e.active, e.row} ||
                        m_axis_tlast !== e.last ||
                        m_axis_tdata !== {e.ld, e.k2, e.k1, e.k0})
                    begin
                        $display("%0t: mismatch expected user %h last %b data %h",
                                 $time, {e.degen, e.active, e.row}, e.last,
                                 {e.ld, e.k2, e.k1, e.k0});
                        $display("%0t:          actual   user %h last %b data %h",
                                 $time, m_axis_tuser, m_axis_tlast, m_axis_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("p1_triangle_poisson_element regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] kappas[6];
        kappas = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
                   32'h0003_8000, 32'h0000_0000};
        kappas[5] = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset kappa
        add_tri(0, 0, 0, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 3'b000);
        add_tri(0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000, 32'h2_0000,
                32'h3_0000, 3'b000);
        add_tri(0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 32'h2_0000,
                32'h3_0000, 3'b000);
        for (int m = 1; m < 8; m++)
            add_tri(0, 0, 32'h2_0000, 0, 0, 32'h3_0000, 32'h1_8000, 32'hFFFF_0000,
                    32'h0_4000, 3'(m));
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 3'b000);
        add_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 3'b000);
        add_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000, 3'b000);
        add_tri(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 3'b000);
        add_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 3'b111);
        add_tri(32'h1_0000, 32'h1_0000, 32'h3_0000, 32'h3_0000, 32'h5_0000,
                32'h5_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 3'b010);
        add_tri(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hF0F0_F0F0, 3'b000);
        for (int i = 0; i < 5; i++)
        begin
            tri_t t;
            t = rnd_tri();
            pend_tris.push_back(t);
            queued_cnt++;
        end
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_kappa(kappas[p]);
            no_idle = (p == 3);
            for (int i = 0; i < 75; i++)
            begin
                tri_t t;
                t = rnd_tri();
                pend_tris.push_back(t);
                queued_cnt++;
            end
            if (p == 2)
                hold_go = 1;
            wait_drained();
        end

        repeat (400) @(negedge clk);
        if (errors == 0 && rows_due.size() == 0)
            $display("p1_triangle_poisson_element regression: pass");
        else
            $display("p1_triangle_poisson_element regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/tpe_pkg.sv
design/tpe_front.sv
design/tpe_queue.sv
design/tpe_back.sv
design/p1_triangle_poisson_element.sv
bench/testbench.sv
